@@ sv/i2ctbe_pkg.sv @@
// Shared types and constants of the I2C target bit engine.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package i2ctbe_pkg;

   localparam int unsigned ReqDataW = 16;
   localparam int unsigned RspDataW = 16;
   localparam int unsigned CsrDataW = 16;

   // register indexes
   localparam logic CSR_OWN_ADDRESS = 1'b0;
   localparam logic CSR_TIMEOUT     = 1'b1;

   localparam logic [7:0]  RW_BIT       = 8'h01;
   localparam logic [7:0]  MSB_BIT      = 8'h80;
   localparam logic [15:0] TIMEOUT_RST  = 16'd1000;
   localparam logic [15:0] WAIT_MAX     = 16'hFFFF;

   typedef enum logic [1:0] {
      END_NONE    = 2'd0,
      END_TIMEOUT = 2'd1,
      END_NACK    = 2'd2,
      END_NO_TX   = 2'd3
   } end_status_type;

   typedef struct packed {
      logic       scl;
      logic       sda;
      logic [7:0] tx_byte;
      logic       tx_ready;
      logic       accept_data;
   } sample_type;

   typedef struct packed {
      logic           sda_drive_low;
      logic           rx_valid;
      logic [7:0]     rx_byte;
      logic           rx_is_address;
      logic           read_mode;
      logic           tx_taken;
      end_status_type end_status;
   } result_type;

endpackage

`default_nettype wire

@@ sv/i2ctbe_in_stage.sv @@
// Input register stage of the I2C target bit engine: holds one sample word.
// Depends on i2ctbe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2ctbe_in_stage (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      load,      // take a new word
   input  wire                      drain,     // held word moves on
   input  i2ctbe_pkg::sample_type   sample_d,
   output logic                     valid,
   output i2ctbe_pkg::sample_type   sample_q
);
   import i2ctbe_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   sample_type sample_ff;

   assign valid_in = load | (valid_ff & ~drain);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         sample_ff <= sample_d;
      end
   end

   assign valid    = valid_ff;
   assign sample_q = sample_ff;

endmodule

`default_nettype wire

@@ sv/i2ctbe_step.sv @@
// Bus state machine of the I2C target bit engine: line edge detection,
// byte shifting, ACK handling and timeout. Depends on i2ctbe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2ctbe_step (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      advance,   // commit one sample
   input  i2ctbe_pkg::sample_type   sample,
   input  wire                      csr_we,
   input  wire                      csr_index,
   input  wire [15:0]               csr_wdata,
   output i2ctbe_pkg::result_type   result
);
   import i2ctbe_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_RX       = 4'd1,
      PH_ACK_FALL = 4'd2,
      PH_ACK_LOW  = 4'd3,
      PH_ACK_END  = 4'd4,
      PH_TX       = 4'd5,
      PH_TX_ACK   = 4'd6,
      PH_TX_NEXT  = 4'd7
   } phase_type;

   logic [6:0]  own_address_ff;
   logic [15:0] timeout_ff;

   logic [1:0]  prev_lines_ff,  prev_lines_in;
   phase_type   phase_ff,       phase_in;
   logic [3:0]  bit_count_ff,   bit_count_in;
   logic [7:0]  rx_shift_ff,    rx_shift_in;
   logic [7:0]  tx_shift_ff,    tx_shift_in;
   logic        addr_seen_ff,   addr_seen_in;
   logic        dir_read_ff,    dir_read_in;
   logic [15:0] wait_ff,        wait_in;
   logic        sda_low_ff,     sda_low_in;

   logic        pscl, psda, rise, fall, start, stop, ack;
   logic [7:0]  rx_next;
   logic [3:0]  bc_next;
   logic [15:0] wait_inc;
   result_type  res;

   assign pscl  = prev_lines_ff[1];
   assign psda  = prev_lines_ff[0];
   assign rise  = ~pscl & sample.scl;
   assign fall  = pscl & ~sample.scl;
   assign start = pscl & sample.scl & psda & ~sample.sda;
   assign stop  = pscl & sample.scl & ~psda & sample.sda;

   assign rx_next  = {rx_shift_ff[6:0], sample.sda};
   assign bc_next  = bit_count_ff + 4'd1;
   assign wait_inc = (wait_ff == WAIT_MAX) ? wait_ff : wait_ff + 16'd1;

   always_comb begin
      prev_lines_in = {sample.scl, sample.sda};
      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      rx_shift_in   = rx_shift_ff;
      tx_shift_in   = tx_shift_ff;
      addr_seen_in  = addr_seen_ff;
      dir_read_in   = dir_read_ff;
      wait_in       = wait_ff;
      sda_low_in    = sda_low_ff;
      ack           = 1'b0;
      res           = '0;

      if (phase_ff == PH_IDLE || start || stop) begin
         if (start) begin
            // new address byte, also on repeated START
            phase_in     = PH_RX;
            bit_count_in = 4'd0;
            rx_shift_in  = 8'd0;
            addr_seen_in = 1'b0;
            dir_read_in  = 1'b0;
            sda_low_in   = 1'b0;
            wait_in      = 16'd0;
         end else if (phase_ff != PH_IDLE) begin
            phase_in     = PH_IDLE;
            sda_low_in   = 1'b0;
            dir_read_in  = 1'b0;
            addr_seen_in = 1'b0;
            bit_count_in = 4'd0;
            wait_in      = 16'd0;
         end
      end else if (!rise && !fall) begin
         wait_in = wait_inc;
         if (wait_inc >= timeout_ff) begin
            res.end_status = END_TIMEOUT;
            phase_in       = PH_IDLE;
            sda_low_in     = 1'b0;
            dir_read_in    = 1'b0;
            addr_seen_in   = 1'b0;
            bit_count_in   = 4'd0;
            wait_in        = 16'd0;
         end
      end else begin
         wait_in = 16'd0;
         case (phase_ff)
            PH_RX: begin
               if (rise) begin
                  rx_shift_in  = rx_next;
                  bit_count_in = bc_next;
                  if (bc_next >= 4'd8) begin
                     res.rx_valid = 1'b1;
                     res.rx_byte  = rx_next;
                     if (!addr_seen_ff) begin
                        res.rx_is_address = 1'b1;
                        ack = (rx_next[7:1] == own_address_ff);
                        if (ack) begin
                           addr_seen_in = 1'b1;
                           dir_read_in  = |(rx_next & RW_BIT);
                        end
                     end else begin
                        ack = sample.accept_data;
                     end
                     bit_count_in = 4'd0;
                     if (ack) begin
                        phase_in = PH_ACK_FALL;
                     end else begin
                        // own refusal: drop back to waiting for START
                        phase_in     = PH_IDLE;
                        sda_low_in   = 1'b0;
                        dir_read_in  = 1'b0;
                        addr_seen_in = 1'b0;
                     end
                  end
               end
            end
            PH_ACK_FALL: begin
               if (fall) begin
                  sda_low_in = 1'b1;
                  phase_in   = PH_ACK_LOW;
               end
            end
            PH_ACK_LOW: begin
               if (rise) begin
                  phase_in = PH_ACK_END;
               end
            end
            PH_ACK_END, PH_TX_NEXT: begin
               if (fall) begin
                  sda_low_in = 1'b0;
                  if (phase_ff == PH_TX_NEXT || dir_read_ff) begin
                     if (sample.tx_ready) begin
                        tx_shift_in  = sample.tx_byte;
                        res.tx_taken = 1'b1;
                        sda_low_in   = ~|(sample.tx_byte & MSB_BIT);
                        bit_count_in = 4'd1;
                        phase_in     = PH_TX;
                     end else begin
                        res.end_status = END_NO_TX;
                        phase_in       = PH_IDLE;
                        dir_read_in    = 1'b0;
                        addr_seen_in   = 1'b0;
                        bit_count_in   = 4'd0;
                     end
                  end else begin
                     phase_in     = PH_RX;
                     bit_count_in = 4'd0;
                     rx_shift_in  = 8'd0;
                  end
               end
            end
            PH_TX: begin
               if (fall) begin
                  if (bit_count_ff >= 4'd8) begin
                     sda_low_in = 1'b0;
                     phase_in   = PH_TX_ACK;
                  end else begin
                     sda_low_in   = ~tx_shift_ff[~bit_count_ff[2:0]];
                     bit_count_in = bc_next;
                  end
               end
            end
            PH_TX_ACK: begin
               if (rise) begin
                  if (sample.sda) begin
                     res.end_status = END_NACK;
                     phase_in       = PH_IDLE;
                     sda_low_in     = 1'b0;
                     dir_read_in    = 1'b0;
                     addr_seen_in   = 1'b0;
                     bit_count_in   = 4'd0;
                  end else begin
                     phase_in = PH_TX_NEXT;
                  end
               end
            end
            default: begin
               phase_in     = PH_IDLE;
               sda_low_in   = 1'b0;
               dir_read_in  = 1'b0;
               addr_seen_in = 1'b0;
               bit_count_in = 4'd0;
            end
         endcase
      end

      res.sda_drive_low = sda_low_in;
      res.read_mode     = dir_read_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff <= 7'd0;
         timeout_ff     <= TIMEOUT_RST;
         prev_lines_ff  <= 2'b11;
         phase_ff       <= PH_IDLE;
         bit_count_ff   <= 4'd0;
         rx_shift_ff    <= 8'd0;
         tx_shift_ff    <= 8'd0;
         addr_seen_ff   <= 1'b0;
         dir_read_ff    <= 1'b0;
         wait_ff        <= 16'd0;
         sda_low_ff     <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_OWN_ADDRESS: own_address_ff <= csr_wdata[6:0];
               CSR_TIMEOUT:     timeout_ff     <= csr_wdata;
               default:         ;
            endcase
         end
         if (advance) begin
            prev_lines_ff <= prev_lines_in;
            phase_ff      <= phase_in;
            bit_count_ff  <= bit_count_in;
            rx_shift_ff   <= rx_shift_in;
            tx_shift_ff   <= tx_shift_in;
            addr_seen_ff  <= addr_seen_in;
            dir_read_ff   <= dir_read_in;
            wait_ff       <= wait_in;
            sda_low_ff    <= sda_low_in;
         end
      end
   end

   assign result = res;

endmodule

`default_nettype wire

@@ sv/i2ctbe_out_stage.sv @@
// Result register of the I2C target bit engine: holds one result word
// until the receiver takes it. Depends on i2ctbe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2ctbe_out_stage (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      load,
   input  i2ctbe_pkg::result_type   result_d,
   input  wire                      taken,
   output logic                     valid,
   output logic                     free,
   output i2ctbe_pkg::result_type   result_q
);
   import i2ctbe_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign free     = ~valid_ff | taken;
   assign valid_in = load | (valid_ff & ~taken);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         result_ff <= result_d;
      end
   end

   assign valid    = valid_ff;
   assign result_q = result_ff;

endmodule

`default_nettype wire

@@ sv/i2ctbe_top.sv @@
// Top level of the I2C target bit engine (i2c_target_bit_engine_unit).
// Depends on i2ctbe_pkg, i2ctbe_in_stage, i2ctbe_step, i2ctbe_out_stage.
//
// Usage:
//   req_*  : one word per oversampled SCL/SDA sample, with the byte offered
//            for reads and the ACK policy for received data.
//   rsp_*  : exactly one result word per sample word, in order.
//   csr_*  : register writes (0 own_address, 1 timeout_samples), taken
//            at any edge with csr_we high; write only while idle.
// Path: a word accepted at req is held in the input register, then passes
//   the bus state machine into the result register, which drives rsp.
// Throughput: one word per cycle while rsp_tready stays high; the state
//   machine commits a sample per cycle when the result register is free.
// Stall: when rsp_tready is low the result holds, the sample waiting in
//   the input register holds, and req_tready stays high while that input
//   register is empty, so one more word is taken before back-pressure.
// Reset: both channels empty, bus logic waits for START with both lines
//   seen high, own_address 0 and timeout_samples 1000.
`timescale 1ns / 1ps
`default_nettype none

module i2c_target_bit_engine_unit (
   input  wire         clock,
   input  wire         reset,
   // request: scl[0] sda[1] tx_byte[9:2] tx_ready[10] accept_data[11]
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,
   // result: sda_drive_low[0] rx_valid[1] rx_byte[9:2] read_mode[10]
   //         tx_taken[11] end_status[13:12]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,
   // result tuser: rx_is_address[0]
   output logic        rsp_tuser,
   // configuration
   input  wire         csr_we,
   input  wire         csr_index,
   input  wire  [15:0] csr_wdata
);
   import i2ctbe_pkg::*;

   sample_type req_sample, held_sample;
   result_type step_result, rsp_result;
   logic       held_valid, advance, out_free, req_take;

   assign req_sample.scl         = req_tdata[0];
   assign req_sample.sda         = req_tdata[1];
   assign req_sample.tx_byte     = req_tdata[9:2];
   assign req_sample.tx_ready    = req_tdata[10];
   assign req_sample.accept_data = req_tdata[11];

   // advance the held sample through the state machine when the result
   // register can take its word
   assign advance    = held_valid & out_free;
   assign req_tready = ~held_valid | advance;
   assign req_take   = req_tvalid & req_tready;

   i2ctbe_in_stage u_in (
      .clock    (clock),
      .reset    (reset),
      .load     (req_take),
      .drain    (advance),
      .sample_d (req_sample),
      .valid    (held_valid),
      .sample_q (held_sample)
   );

   i2ctbe_step u_step (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .sample    (held_sample),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .result    (step_result)
   );

   i2ctbe_out_stage u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .result_d (step_result),
      .taken    (rsp_tready),
      .valid    (rsp_tvalid),
      .free     (out_free),
      .result_q (rsp_result)
   );

   assign rsp_tdata = {2'b00,
                       rsp_result.end_status,
                       rsp_result.tx_taken,
                       rsp_result.read_mode,
                       rsp_result.rx_byte,
                       rsp_result.rx_valid,
                       rsp_result.sda_drive_low};
   assign rsp_tuser = rsp_result.rx_is_address;

endmodule

`default_nettype wire
